/* sv/shsr_pkg.sv */
// Shared types, constants and the microcode ROM of the ranking sorter.
package shsr_pkg;

  localparam int SHSR_MAX_PLAYERS = 64;
  localparam int ID_W             = 16;
  localparam int MONEY_W          = 48;
  localparam int RANK_W           = 6;
  localparam int LIMIT_W          = 7;
  localparam int RESULT_CAP       = 64;
  localparam logic [LIMIT_W-1:0] RANK_LIMIT_RESET = 7'd10;

  // Microcode step addresses
  typedef enum logic [3:0] {
    S_LOAD      = 4'd0,
    S_GAP_INIT  = 4'd1,
    S_GAP_TEST  = 4'd2,
    S_I_TEST    = 4'd3,
    S_HOLD      = 4'd4,
    S_READ      = 4'd5,
    S_CMP       = 4'd6,
    S_SHIFT     = 4'd7,
    S_PLACE     = 4'd8,
    S_GAP_HALF  = 4'd9,
    S_EMIT_INIT = 4'd10,
    S_EMIT_READ = 4'd11,
    S_EMIT_OUT  = 4'd12,
    S_DONE      = 4'd13
  } step_t;

  // Stall a step until a transfer is possible
  typedef enum logic [1:0] {
    W_NONE,
    W_IN,
    W_OUT
  } wait_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOT_LAST,
    C_GAP_ZERO,
    C_I_GE_N,
    C_J_LT_GAP,
    C_NOT_LESS,
    C_K_EQ_EMIT
  } cond_t;

  // Memory read address select
  typedef enum logic [1:0] {
    RD_NONE,
    RD_I,
    RD_JG,
    RD_K
  } rd_t;

  // Memory write source select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_IN,
    WR_SHIFT,
    WR_HOLD
  } wr_t;

  // Datapath register operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_GAP_INIT,
    OP_I_INIT,
    OP_GAP_HALF,
    OP_HOLD,
    OP_J_DEC,
    OP_I_INC,
    OP_EMIT_INIT,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    wait_t wt;
    cond_t cond;
    step_t target;
    rd_t   rd;
    wr_t   wr;
    op_t   op;
  } ctrl_t;

  // Flags the datapath hands back to the sequencer
  typedef struct packed {
    logic gap_zero;
    logic i_ge_n;
    logic j_lt_gap;
    logic not_less;
    logic k_eq_emit;
    logic out_free;
  } status_t;

  // Control store: one word per step
  function automatic ctrl_t shsr_rom(input step_t s);
    ctrl_t w;
    w = '{wt: W_NONE, cond: C_NEXT, target: S_LOAD, rd: RD_NONE, wr: WR_NONE, op: OP_NONE};
    unique case (s)
      S_LOAD: begin
        w.wt = W_IN; w.cond = C_NOT_LAST; w.target = S_LOAD;
        w.wr = WR_IN; w.op = OP_LOAD;
      end
      S_GAP_INIT: begin
        w.op = OP_GAP_INIT;
      end
      S_GAP_TEST: begin
        w.cond = C_GAP_ZERO; w.target = S_EMIT_INIT; w.op = OP_I_INIT;
      end
      S_I_TEST: begin
        w.cond = C_I_GE_N; w.target = S_GAP_HALF; w.rd = RD_I;
      end
      S_HOLD: begin
        w.op = OP_HOLD;
      end
      S_READ: begin
        w.cond = C_J_LT_GAP; w.target = S_PLACE; w.rd = RD_JG;
      end
      S_CMP: begin
        w.cond = C_NOT_LESS; w.target = S_PLACE;
      end
      S_SHIFT: begin
        w.cond = C_ALWAYS; w.target = S_READ; w.wr = WR_SHIFT; w.op = OP_J_DEC;
      end
      S_PLACE: begin
        w.cond = C_ALWAYS; w.target = S_I_TEST; w.wr = WR_HOLD; w.op = OP_I_INC;
      end
      S_GAP_HALF: begin
        w.cond = C_ALWAYS; w.target = S_GAP_TEST; w.op = OP_GAP_HALF;
      end
      S_EMIT_INIT: begin
        w.op = OP_EMIT_INIT;
      end
      S_EMIT_READ: begin
        w.cond = C_K_EQ_EMIT; w.target = S_DONE; w.rd = RD_K;
      end
      S_EMIT_OUT: begin
        w.wt = W_OUT; w.cond = C_ALWAYS; w.target = S_EMIT_READ; w.op = OP_EMIT;
      end
      S_DONE: begin
        w.cond = C_ALWAYS; w.target = S_LOAD; w.op = OP_CLEAR;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/shsr_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module shsr_seq
  import shsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    is_last,
  input  status_t status,
  output logic    in_ready,
  output ctrl_t   ctl
);

  step_t pc;
  step_t pc_next;
  ctrl_t word;
  logic  go;
  logic  take;

  // Fetch the control word of the current step
  always_comb begin
    word = shsr_rom(pc);
  end

  // Decide whether the step may run and whether it jumps
  always_comb begin
    unique case (word.wt)
      W_NONE:  go = 1'b1;
      W_IN:    go = in_valid;
      W_OUT:   go = status.out_free;
      default: go = 1'b0;
    endcase
    unique case (word.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_LAST:  take = !is_last;
      C_GAP_ZERO:  take = status.gap_zero;
      C_I_GE_N:    take = status.i_ge_n;
      C_J_LT_GAP:  take = status.j_lt_gap;
      C_NOT_LESS:  take = status.not_less;
      C_K_EQ_EMIT: take = status.k_eq_emit;
      default:     take = 1'b0;
    endcase
  end

  // Next step: hold, jump or advance
  always_comb begin
    if (!go) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = word.target;
    end else begin
      pc_next = step_t'(pc + 4'd1);
    end
  end

  // Drive the datapath; drop side effects of a stalled step
  always_comb begin
    ctl = word;
    in_ready = (word.wt == W_IN);
    if (!go) begin
      ctl.wr = WR_NONE;
      ctl.op = OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* sv/shsr_dp.sv */
// Sort datapath: record memory, index registers, compare and result register.
module shsr_dp
  import shsr_pkg::*;
#(
  parameter int MAX_PLAYERS = SHSR_MAX_PLAYERS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_t                     ctl,
  input  logic [LIMIT_W-1:0]        rank_limit,
  input  logic [ID_W-1:0]           player_id,
  input  logic signed [MONEY_W-1:0] money,
  input  logic                      out_ready,
  output status_t                   status,
  output logic                      out_valid,
  output logic [ID_W-1:0]           out_player_id,
  output logic signed [MONEY_W-1:0] out_money,
  output logic [RANK_W-1:0]         rank,
  output logic                      overflow,
  output logic                      last_result
);

  localparam int ADDR_W  = $clog2(MAX_PLAYERS);
  localparam int CNT_W   = $clog2(MAX_PLAYERS + 1);
  localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int ENTRY_W = ID_W + MONEY_W;

  logic [ENTRY_W-1:0] mem [MAX_PLAYERS];
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] wdata;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic               re;
  logic               we;

  logic [CNT_W-1:0]   count;
  logic               ovf;
  logic [CNT_W-1:0]   gap;
  logic [CNT_W-1:0]   i;
  logic [CNT_W-1:0]   j;
  logic [LIMIT_W-1:0] k;
  logic [LIMIT_W-1:0] emit;
  logic [ID_W-1:0]    hold_id;
  logic signed [MONEY_W-1:0] hold_money;

  logic               full;
  logic signed [MONEY_W-1:0] rd_money;
  logic [CMP_W-1:0]   emit_min;
  logic [LIMIT_W-1:0] k_inc;

  assign full     = (count == CNT_W'(MAX_PLAYERS));
  assign rd_money = rdata[MONEY_W-1:0];
  assign k_inc    = k + 7'd1;

  // Number of results: least of count, limit and cap
  always_comb begin
    if (CMP_W'(count) < CMP_W'(rank_limit)) begin
      emit_min = CMP_W'(count);
    end else begin
      emit_min = CMP_W'(rank_limit);
    end
    if (emit_min > CMP_W'(RESULT_CAP)) begin
      emit_min = CMP_W'(RESULT_CAP);
    end
  end

  // Select memory read port
  always_comb begin
    re = 1'b1;
    case (ctl.rd)
      RD_I:    raddr = ADDR_W'(i);
      RD_JG:   raddr = ADDR_W'(j - gap);
      RD_K:    raddr = ADDR_W'(k);
      default: begin
        raddr = ADDR_W'(i);
        re    = 1'b0;
      end
    endcase
  end

  // Select memory write port
  always_comb begin
    we    = 1'b0;
    waddr = ADDR_W'(j);
    wdata = {hold_id, hold_money};
    case (ctl.wr)
      WR_IN: begin
        we    = !full;
        waddr = ADDR_W'(count);
        wdata = {player_id, money};
      end
      WR_SHIFT: begin
        we    = 1'b1;
        wdata = rdata;
      end
      WR_HOLD: begin
        we    = 1'b1;
      end
      default: we = 1'b0;
    endcase
  end

  // Record memory with registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Flags for the sequencer
  always_comb begin
    status.gap_zero  = (gap == '0);
    status.i_ge_n    = (i >= count);
    status.j_lt_gap  = (j < gap);
    status.not_less  = !(rd_money < hold_money);
    status.k_eq_emit = (k == emit);
    status.out_free  = !out_valid || out_ready;
  end

  // Count and overflow of the current set
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (ctl.op == OP_LOAD) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end else if (ctl.op == OP_CLEAR) begin
      count <= '0;
      ovf   <= 1'b0;
    end
  end

  // Gap, index and held-record registers
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_GAP_INIT:  gap <= count >> 1;
      OP_GAP_HALF:  gap <= gap >> 1;
      OP_I_INIT:    i   <= gap;
      OP_I_INC:     i   <= i + CNT_W'(1);
      OP_HOLD: begin
        hold_id    <= rdata[ENTRY_W-1:MONEY_W];
        hold_money <= rd_money;
        j          <= i;
      end
      OP_J_DEC:     j   <= j - gap;
      OP_EMIT_INIT: begin
        emit <= LIMIT_W'(emit_min);
        k    <= '0;
      end
      OP_EMIT:      k   <= k_inc;
      default: ;
    endcase
  end

  // Result register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT) begin
      out_player_id <= rdata[ENTRY_W-1:MONEY_W];
      out_money     <= rd_money;
      rank          <= k[RANK_W-1:0];
      overflow      <= ovf;
      last_result   <= (k_inc == emit);
    end
  end

endmodule

/* sv/shell_sort_ranking.sv */
// Top level of the ranking sorter: configuration register, sequencer and datapath.
//
// channel  signals                                        direction
// in       in_valid/in_ready: player_id, money, is_last    into block
// out      out_valid/out_ready: out_player_id, out_money,  out of block
//          rank, overflow, last_result
// cfg      cfg_valid/cfg_ready: cfg_data (rank_limit)      into block
//
// Loading accepts one record per cycle. After the last record the Shell sort runs on
// the record memory (one read port, one write port); each gap pass halves the gap and
// places each visited record ahead of those with less money. Each result is read, then
// loaded into the result register; a full register with out_ready low stalls the sequencer.
// Synchronous reset sets rank_limit to 10 and empties the set; cfg_ready is always high.
module shell_sort_ranking
  import shsr_pkg::*;
#(
  parameter int MAX_PLAYERS = SHSR_MAX_PLAYERS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ID_W-1:0]           player_id,
  input  logic signed [MONEY_W-1:0] money,
  input  logic                      is_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ID_W-1:0]           out_player_id,
  output logic signed [MONEY_W-1:0] out_money,
  output logic [RANK_W-1:0]         rank,
  output logic                      overflow,
  output logic                      last_result,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [LIMIT_W-1:0]        cfg_data
);

  logic [LIMIT_W-1:0] rank_limit;
  ctrl_t              ctl;
  status_t            status;

  assign cfg_ready = 1'b1;

  // Hold rank limit; update on config transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_limit <= RANK_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rank_limit <= cfg_data;
    end
  end

  shsr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .is_last  (is_last),
    .status   (status),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  shsr_dp #(
    .MAX_PLAYERS (MAX_PLAYERS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .rank_limit    (rank_limit),
    .player_id     (player_id),
    .money         (money),
    .out_ready     (out_ready),
    .status        (status),
    .out_valid     (out_valid),
    .out_player_id (out_player_id),
    .out_money     (out_money),
    .rank          (rank),
    .overflow      (overflow),
    .last_result   (last_result)
  );

  // Ranks within a set climb by one from transfer to transfer
  a_rank_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=>
      !out_valid || (rank == $past(rank) + 6'd1))
    else $error("rank did not advance by one");

  // Overflow flag is the same across a set
  a_ovf_const: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_result |=>
      !out_valid || (overflow == $past(overflow)))
    else $error("overflow changed within a set");

  // Last record of a set stops loading while the sort runs
  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last |=> !in_ready)
    else $error("input still open after last record");

  // Nothing is emitted while records are loading
  a_no_emit_on_load: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (ctl.op != OP_EMIT))
    else $error("result loaded during record load");

endmodule

/* tb/ranking_checker.sv */
// Checker for the ranking sorter: predicts ranked results and compares them.
module ranking_checker
  import shsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [ID_W-1:0]           player_id,
  input  logic signed [MONEY_W-1:0] money,
  input  logic                      is_last,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [ID_W-1:0]           out_player_id,
  input  logic signed [MONEY_W-1:0] out_money,
  input  logic [RANK_W-1:0]         rank,
  input  logic                      overflow,
  input  logic                      last_result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [LIMIT_W-1:0]        cfg_data,
  output int                        mismatches,
  output int                        results_due
);

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [MONEY_W-1:0] money;
    logic [RANK_W-1:0]         rank;
    logic                      dropped;
    logic                      is_final;
  } ranked_t;

  // Shadow copy of the record store and the rank limit
  logic [ID_W-1:0]           held_ids   [SHSR_MAX_PLAYERS];
  logic signed [MONEY_W-1:0] held_money [SHSR_MAX_PLAYERS];
  int                        held_count;
  logic                      held_dropped;
  logic [LIMIT_W-1:0]        limit_q;
  ranked_t                   ranking_due [$];
  int                        bad_results = 0;

  assign mismatches = bad_results;

  // Gapped insertion passes with halving gaps; move up only on strictly less money
  task automatic sort_held(input int n);
    int                        gap;
    int                        i;
    int                        j;
    logic [ID_W-1:0]           hold_id;
    logic signed [MONEY_W-1:0] hold_money;
    for (gap = n / 2; gap > 0; gap = gap / 2) begin
      for (i = gap; i < n; i++) begin
        hold_id = held_ids[i];
        hold_money = held_money[i];
        j = i;
        while (j >= gap && held_money[j - gap] < hold_money) begin
          held_ids[j] = held_ids[j - gap];
          held_money[j] = held_money[j - gap];
          j -= gap;
        end
        held_ids[j] = hold_id;
        held_money[j] = hold_money;
      end
    end
  endtask

  task automatic report(input string what, input ranked_t got, input ranked_t want);
    bad_results++;
    if (bad_results <= 10) begin
      $display("%s: got id %h money %h rank %0d ovf %b last %b", what,
               got.id, got.money, got.rank, got.dropped, got.is_final);
      $display("  expected id %h money %h rank %0d ovf %b last %b",
               want.id, want.money, want.rank, want.dropped, want.is_final);
    end
  endtask

  always @(posedge clk) begin
    ranked_t got;
    ranked_t want;
    int      emit;
    if (rst) begin
      held_count = 0;
      held_dropped = 1'b0;
      limit_q = RANK_LIMIT_RESET;
      ranking_due.delete();
    end else begin
      // Track the rank limit register
      if (cfg_valid && cfg_ready)
        limit_q = cfg_data;

      // Compare each result transfer with the oldest prediction
      if (out_valid && out_ready) begin
        got = '{id: out_player_id, money: out_money, rank: rank,
                dropped: overflow, is_final: last_result};
        if (ranking_due.size() == 0) begin
          report("unexpected result", got, '0);
        end else begin
          want = ranking_due.pop_front();
          if (got.id !== want.id || got.money !== want.money || got.rank !== want.rank ||
              got.dropped !== want.dropped || got.is_final !== want.is_final)
            report("result mismatch", got, want);
        end
      end

      // Store the record, or drop it when the store is full; rank on the last one
      if (in_valid && in_ready) begin
        if (held_count < SHSR_MAX_PLAYERS) begin
          held_ids[held_count] = player_id;
          held_money[held_count] = money;
          held_count++;
        end else begin
          held_dropped = 1'b1;
        end
        if (is_last) begin
          sort_held(held_count);
          emit = (held_count < int'(limit_q)) ? held_count : int'(limit_q);
          if (emit > RESULT_CAP)
            emit = RESULT_CAP;
          for (int k = 0; k < emit; k++) begin
            ranking_due.push_back('{id: held_ids[k], money: held_money[k],
                                    rank: RANK_W'(k), dropped: held_dropped,
                                    is_final: (k + 1 == emit)});
          end
          held_count = 0;
          held_dropped = 1'b0;
        end
      end
    end
    results_due <= ranking_due.size();
  end

endmodule

/* tb/tb_shell_sort_ranking.sv */
// Testbench top for the ranking sorter: stimulus, back-pressure and verdict.
module tb_shell_sort_ranking;
  import shsr_pkg::*;

  localparam int DRAIN_CYCLES   = 12000;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int LONG_HOLD      = 400;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [ID_W-1:0]           player_id = '0;
  logic signed [MONEY_W-1:0] money = '0;
  logic                      is_last = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ID_W-1:0]           out_player_id;
  logic signed [MONEY_W-1:0] out_money;
  logic [RANK_W-1:0]         rank;
  logic                      overflow;
  logic                      last_result;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [LIMIT_W-1:0]        cfg_data = '0;

  int                        mismatches;
  int                        results_due;
  int                        quiet_cycles;
  int unsigned               ready_pause;
  int unsigned               results_taken;
  bit                        steady = 1'b0;
  logic signed [MONEY_W-1:0] tie_pool [4];

  localparam logic signed [MONEY_W-1:0] MONEY_MAX = {1'b0, {(MONEY_W-1){1'b1}}};
  localparam logic signed [MONEY_W-1:0] MONEY_MIN = {1'b1, {(MONEY_W-1){1'b0}}};

  always #10 clk = ~clk;

  shell_sort_ranking DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .player_id(player_id), .money(money), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_player_id(out_player_id), .out_money(out_money), .rank(rank),
    .overflow(overflow), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ranking_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .player_id(player_id), .money(money), .is_last(is_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_player_id(out_player_id), .out_money(out_money), .rank(rank),
    .overflow(overflow), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .results_due(results_due)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 2);
    if (r < 96)
      return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // Money mix: full-range values, extremes, small values near zero and ties
  function automatic logic signed [MONEY_W-1:0] pick_money();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return MONEY_MAX;
      1: return MONEY_MIN;
      2, 3: return tie_pool[$urandom_range(0, 3)];
      4: return {{(MONEY_W-17){r[16]}}, r[16:0]};
      default: return r[MONEY_W-1:0];
    endcase
  endfunction

  // Offer one record and hold it until the transfer
  task automatic send_record(input logic [ID_W-1:0] id, input logic signed [MONEY_W-1:0] m,
                             input logic last);
    int unsigned idle;
    idle = gap_len();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    player_id <= id;
    money <= m;
    is_last <= last;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_set(input int n);
    for (int t = 0; t < 4; t++)
      tie_pool[t] = MONEY_W'({$urandom, $urandom});
    for (int i = 0; i < n; i++)
      send_record(ID_W'($urandom), pick_money(), i == n - 1);
  endtask

  function automatic int pick_set_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return $urandom_range(1, 6);
    if (r < 88)
      return $urandom_range(7, 20);
    if (r < 96)
      return $urandom_range(21, 63);
    return $urandom_range(64, 68);
  endfunction

  // Drop valid, wait for every predicted result, then let a pending sort finish
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random back-pressure plus long hold-offs that fill the block up
  always @(posedge clk) begin : receiver
    int unsigned pause;
    if (rst) begin
      out_ready <= 1'b0;
      ready_pause <= 0;
      results_taken <= 0;
    end else if (ready_pause != 0) begin
      ready_pause <= ready_pause - 1;
    end else begin
      if (out_valid && out_ready)
        results_taken <= results_taken + 1;
      if (out_valid && out_ready && (results_taken == 40 || results_taken == 300)) begin
        out_ready <= 1'b0;
        ready_pause <= LONG_HOLD - 1;
      end else begin
        pause = ((out_valid && out_ready) || $urandom_range(0, 7) == 0) ? gap_len() : 0;
        out_ready <= (pause == 0);
        ready_pause <= (pause == 0) ? 0 : pause - 1;
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [LIMIT_W-1:0] lim_plan [8];
    int                 quota [8];
    int                 sent;
    int                 n;

    lim_plan = '{7'd64, 7'd127, 7'd1, 7'd0, 7'd10, 7'd0, 7'd0, 7'd64};
    quota = '{80, 70, 45, 45, 45, 20, 45, 70};
    lim_plan[3] = LIMIT_W'($urandom_range(2, 63));
    lim_plan[6] = LIMIT_W'($urandom_range(2, 63));
    for (int t = 0; t < 4; t++)
      tie_pool[t] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: single record at the top extreme, under the reset limit
    send_record(16'hFFFF, MONEY_MAX, 1'b1);
    // Extremes and equal money in one set
    send_record(16'h0000, MONEY_MIN, 1'b0);
    send_record(16'h1234, '0, 1'b0);
    send_record(16'hABCD, -48'sd1, 1'b0);
    send_record(16'h5555, '0, 1'b0);
    send_record(16'hFFFF, MONEY_MAX, 1'b1);
    // More records than the limit, with repeated money values
    for (int i = 0; i < 12; i++)
      send_record(16'(i), MONEY_W'(((i % 4) - 2) * 65536), i == 11);
    drain();

    // Limit of zero: the set ends with no result
    write_limit(7'd0);
    send_record(16'h00FF, 48'sd1, 1'b0);
    send_record(16'hFF00, -48'sd65536, 1'b0);
    send_record(16'h0F0F, 48'sd65536, 1'b1);
    drain();

    write_limit(7'd1);
    send_record(16'h7777, 48'sd5, 1'b0);
    send_record(16'h8888, 48'sd9, 1'b1);
    drain();

    // Random phases, each under its own rank limit
    for (int p = 0; p < 8; p++) begin
      write_limit(lim_plan[p]);
      steady = (p == 4);
      sent = 0;
      if (p == 0 || p == 1 || p == 7) begin
        n = (p == 0) ? 70 : (p == 1) ? 64 : $urandom_range(65, 68);
        send_set(n);
        sent += n;
      end
      while (sent < quota[p]) begin
        n = pick_set_size();
        send_set(n);
        sent += n;
      end
      drain();
    end

    if (mismatches == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      if (results_due != 0)
        $display("%0d predicted results never arrived", results_due);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* shell_sort_ranking.f */
sv/shsr_pkg.sv
sv/shsr_seq.sv
sv/shsr_dp.sv
sv/shell_sort_ranking.sv
tb/ranking_checker.sv
tb/tb_shell_sort_ranking.sv
